// ===== hdl/ps2mc_pkg.sv =====
// ============================================================================
// ps2mc_pkg
// Shared types, codes and constants for the PS/2 mouse cursor tracker.
// ============================================================================
package ps2mc_pkg;

    typedef enum logic [1:0] {
        KIND_MOUSE_BYTE = 2'd0,
        KIND_SET_POS    = 2'd1,
        KIND_CLEAR      = 2'd2,
        KIND_UNUSED     = 2'd3
    } kind_t;

    typedef enum logic [0:0] {
        REG_GRID_COLUMNS = 1'b0,
        REG_GRID_ROWS    = 1'b1
    } reg_index_t;

    localparam logic [1:0] PHASE_STATUS = 2'd0;
    localparam logic [1:0] PHASE_DX     = 2'd1;
    localparam logic [1:0] PHASE_DY     = 2'd2;

    localparam logic [7:0] GRID_COLUMNS_RESET = 8'd80;
    localparam logic [7:0] GRID_ROWS_RESET    = 8'd25;
    localparam logic [7:0] POS_X_RESET        = 8'd40;
    localparam logic [7:0] POS_Y_RESET        = 8'd12;

    // button bits
    localparam int BTN_LEFT   = 0;
    localparam int BTN_RIGHT  = 1;
    localparam int BTN_MIDDLE = 2;

    // event flag bits
    localparam int EVT_LEFT_PRESS   = 0;
    localparam int EVT_RIGHT_PRESS  = 1;
    localparam int EVT_LEFT_RELEASE = 2;
    localparam int EVT_MOTION       = 3;

    typedef struct packed {
        logic [1:0] byte_phase;
        logic [7:0] status_byte;
        logic [7:0] dx_byte;
        logic [7:0] pos_x;
        logic [7:0] pos_y;
        logic [7:0] old_x;
        logic [7:0] old_y;
        logic [2:0] button_bits;
        logic [3:0] event_flags;
    } track_state_t;

    // Clamp a signed coordinate into [0, size-1]; size 0 acts as 1.
    function automatic logic [7:0] clamp_coord(input logic signed [16:0] v,
                                               input logic [7:0] size);
        logic [7:0]         top;
        logic signed [16:0] top_s;
        logic [7:0]         res;
        top   = (size == 8'd0) ? 8'd0 : size - 8'd1;
        top_s = signed'({9'd0, top});
        if (v < 17'sd0)
            res = 8'd0;
        else if (v > top_s)
            res = top;
        else
            res = v[7:0];
        return res;
    endfunction

endpackage

// ===== hdl/ps2_mouse_packet_cursor_tracker_top.sv =====
// ============================================================================
// ps2_mouse_packet_cursor_tracker_top
// PS/2 mouse packet decoder with a clamped text-grid cursor.
// ============================================================================
// Each item is registered on entry, then decoded combinationally into the
// tracker state and the result register. The result item is presented once
// the input register drains into the result register; one item can be
// accepted every cycle while the receiver keeps up. The result fields are
// the tracker state itself plus the packet_done bit; the state only moves
// when the result register is loaded, so a stalled result holds.
// Mouse bytes are grouped three at a time by a phase counter (no sync check);
// the third byte updates buttons, edge flags, previous and current position.
// Grid size registers may be written only while the block is idle; a smaller
// grid takes effect at the next packet or set-position item.
module ps2_mouse_packet_cursor_tracker_top
(
    input  logic                clk,
    input  logic                rst_n,
    // input item channel
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          kind,
    input  logic [7:0]          rx_byte,
    input  logic signed [15:0]  set_x,
    input  logic signed [15:0]  set_y,
    // result item channel
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          cursor_x,
    output logic [7:0]          cursor_y,
    output logic [7:0]          prev_x,
    output logic [7:0]          prev_y,
    output logic                left_down,
    output logic                right_down,
    output logic                middle_down,
    output logic                left_press_edge,
    output logic                right_press_edge,
    output logic                left_release_edge,
    output logic                motion_seen,
    output logic                packet_done,
    // configuration
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [7:0]          cfg_data
);
    import ps2mc_pkg::*;

    // config registers
    logic [7:0]         grid_columns_reg;
    logic [7:0]         grid_rows_reg;

    // input stage
    logic               in_valid_reg;
    kind_t              kind_reg;
    logic [7:0]         rx_byte_reg;
    logic signed [15:0] set_x_reg;
    logic signed [15:0] set_y_reg;

    // tracker state doubles as the result payload
    track_state_t       state_reg;
    track_state_t       state_next;
    logic               done_next;
    logic               done_reg;
    logic               out_valid_reg;

    logic               advance;

    // the input stage drains whenever the result slot is free or being taken
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_columns_reg <= GRID_COLUMNS_RESET;
            grid_rows_reg    <= GRID_ROWS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_GRID_COLUMNS: grid_columns_reg <= cfg_data;
                REG_GRID_ROWS:    grid_rows_reg    <= cfg_data;
                default:          grid_rows_reg    <= grid_rows_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    // payload of the input stage, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            kind_reg    <= kind_t'(kind);
            rx_byte_reg <= rx_byte;
            set_x_reg   <= set_x;
            set_y_reg   <= set_y;
        end
    end

    ps2mc_update u_update
    (
        .state        (state_reg),
        .kind         (kind_reg),
        .rx_byte      (rx_byte_reg),
        .set_x        (set_x_reg),
        .set_y        (set_y_reg),
        .grid_columns (grid_columns_reg),
        .grid_rows    (grid_rows_reg),
        .state_next   (state_next),
        .done         (done_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '{byte_phase:  PHASE_STATUS,
                               status_byte: 8'd0,
                               dx_byte:     8'd0,
                               pos_x:       POS_X_RESET,
                               pos_y:       POS_Y_RESET,
                               old_x:       POS_X_RESET,
                               old_y:       POS_Y_RESET,
                               button_bits: 3'd0,
                               event_flags: 4'd0};
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg <= state_next;
                done_reg  <= done_next;
            end
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid         = out_valid_reg;
    assign cursor_x          = state_reg.pos_x;
    assign cursor_y          = state_reg.pos_y;
    assign prev_x            = state_reg.old_x;
    assign prev_y            = state_reg.old_y;
    assign left_down         = state_reg.button_bits[BTN_LEFT];
    assign right_down        = state_reg.button_bits[BTN_RIGHT];
    assign middle_down       = state_reg.button_bits[BTN_MIDDLE];
    assign left_press_edge   = state_reg.event_flags[EVT_LEFT_PRESS];
    assign right_press_edge  = state_reg.event_flags[EVT_RIGHT_PRESS];
    assign left_release_edge = state_reg.event_flags[EVT_LEFT_RELEASE];
    assign motion_seen       = state_reg.event_flags[EVT_MOTION];
    assign packet_done       = done_reg;

    // phase counter only ever cycles 0..2
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.byte_phase != 2'd3)
        else $error("byte phase reached 3");

    // a completed packet always leaves the phase counter at the status byte
    a_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && packet_done |-> state_reg.byte_phase == PHASE_STATUS)
        else $error("packet done with phase not reset");

    // a waiting item moves to an empty result slot in the next cycle
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_valid_reg |=> out_valid_reg)
        else $error("input stage did not drain into empty result slot");

    // back-pressure only when the input stage holds an item
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> in_valid_reg && out_valid_reg && !out_ready)
        else $error("input stalled without cause");

    // state does not move while a result waits
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(state_reg) && $stable(done_reg))
        else $error("tracker state changed under a stalled result");

endmodule

// ===== hdl/ps2mc_update.sv =====
// ============================================================================
// ps2mc_update
// Next-state logic: packet assembly, cursor move/clamp, edge flags.
// ============================================================================
module ps2mc_update
(
    input  ps2mc_pkg::track_state_t state,
    input  ps2mc_pkg::kind_t        kind,
    input  logic [7:0]              rx_byte,
    input  logic signed [15:0]      set_x,
    input  logic signed [15:0]      set_y,
    input  logic [7:0]              grid_columns,
    input  logic [7:0]              grid_rows,
    output ps2mc_pkg::track_state_t state_next,
    output logic                    done
);
    import ps2mc_pkg::*;

    logic signed [16:0] sum_x;
    logic signed [16:0] sum_y;
    logic [2:0]         now_btn;
    logic [3:0]         flags;

    // dy is the negated third byte
    assign sum_x = signed'({9'd0, state.pos_x}) + 17'(signed'(state.dx_byte));
    assign sum_y = signed'({9'd0, state.pos_y}) - 17'(signed'(rx_byte));
    assign now_btn = state.status_byte[2:0];

    always_comb
    begin
        flags                   = '0;
        flags[EVT_LEFT_PRESS]   = now_btn[BTN_LEFT] & ~state.button_bits[BTN_LEFT];
        flags[EVT_RIGHT_PRESS]  = now_btn[BTN_RIGHT] & ~state.button_bits[BTN_RIGHT];
        flags[EVT_LEFT_RELEASE] = ~now_btn[BTN_LEFT] & state.button_bits[BTN_LEFT];
        flags[EVT_MOTION]       = (state.dx_byte != 8'd0) || (rx_byte != 8'd0);
    end

    always_comb
    begin
        state_next = state;
        done       = 1'b0;
        case (kind)
            KIND_MOUSE_BYTE:
            begin
                if (state.byte_phase == PHASE_DX)
                begin
                    state_next.dx_byte    = rx_byte;
                    state_next.byte_phase = PHASE_DY;
                end
                else if (state.byte_phase == PHASE_DY)
                begin
                    state_next.old_x       = state.pos_x;
                    state_next.old_y       = state.pos_y;
                    state_next.pos_x       = clamp_coord(sum_x, grid_columns);
                    state_next.pos_y       = clamp_coord(sum_y, grid_rows);
                    state_next.event_flags = flags;
                    state_next.button_bits = now_btn;
                    state_next.byte_phase  = PHASE_STATUS;
                    done                   = 1'b1;
                end
                else
                begin
                    // phase 0, and the unreachable phase 3
                    state_next.status_byte = rx_byte;
                    state_next.byte_phase  = PHASE_DX;
                end
            end
            KIND_SET_POS:
            begin
                state_next.pos_x = clamp_coord(17'(set_x), grid_columns);
                state_next.pos_y = clamp_coord(17'(set_y), grid_rows);
            end
            KIND_CLEAR:
            begin
                state_next.event_flags = state.event_flags & (4'd1 << EVT_LEFT_RELEASE);
            end
            default:
            begin
                state_next = state;
            end
        endcase
    end

endmodule
